// ----- hw/rtl/obbsat_pkg.sv -----
// Shared widths, alignment shifts and the frame bundle for the oriented box overlap test.
package obbsat_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DirW    = 16;
  localparam int unsigned ExtW    = 23;
  localparam int unsigned MarginW = 8;

  localparam logic [MarginW-1:0] MarginReset = 8'd2;

  localparam int unsigned DeltaW     = CoordW + 1;
  localparam int unsigned DirProdW   = 2 * DirW;
  localparam int unsigned RotW       = DirProdW + 1;
  localparam int unsigned AbsRotW    = DirProdW;
  localparam int unsigned TW         = DeltaW + DirW;
  localparam int unsigned AbsTW      = TW - 1;
  localparam int unsigned ExtProdW   = ExtW + AbsRotW;
  localparam int unsigned SplitLo    = 20;
  localparam int unsigned SplitHiW   = TW - SplitLo;
  localparam int unsigned PartW      = SplitHiW + RotW;
  localparam int unsigned WideW      = 74;
  localparam int unsigned LhsW       = AbsTW + 14;
  localparam int unsigned RhsW       = 57;
  localparam int unsigned SumW       = ExtProdW + 1;

  localparam int unsigned EpsShift    = 14;
  localparam int unsigned LhsShift    = 14;
  localparam int unsigned ExtAShift   = 28;
  localparam int unsigned SumShift    = 14;
  localparam int unsigned ExtBShift   = 42;

  typedef struct packed {
    logic signed [TW-1:0]   tx;
    logic signed [TW-1:0]   ty;
    logic signed [RotW-1:0] r11;
    logic signed [RotW-1:0] r12;
    logic [ExtW-1:0]        aw;
    logic [ExtW-1:0]        ah;
    logic [ExtW-1:0]        bw;
    logic [ExtW-1:0]        bh;
    logic [ExtProdW-1:0]    bw_a11;
    logic [ExtProdW-1:0]    bh_a12;
    logic [ExtProdW-1:0]    bw_a12;
    logic [ExtProdW-1:0]    bh_a11;
    logic [ExtProdW-1:0]    aw_a11;
    logic [ExtProdW-1:0]    ah_a12;
    logic [ExtProdW-1:0]    aw_a12;
    logic [ExtProdW-1:0]    ah_a11;
  } frame_t;

endpackage

// ----- hw/rtl/obbsat_frame.sv -----
// Stages 1-3: center deltas, rotation terms, frame transform and extent products.
module obbsat_frame import obbsat_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [MarginW-1:0]       margin_i,
  input  logic signed [CoordW-1:0] box_a_center_x_i,
  input  logic signed [CoordW-1:0] box_a_center_y_i,
  input  logic signed [DirW-1:0]   box_a_dir_x_i,
  input  logic signed [DirW-1:0]   box_a_dir_y_i,
  input  logic [ExtW-1:0]          box_a_half_w_i,
  input  logic [ExtW-1:0]          box_a_half_h_i,
  input  logic signed [CoordW-1:0] box_b_center_x_i,
  input  logic signed [CoordW-1:0] box_b_center_y_i,
  input  logic signed [DirW-1:0]   box_b_dir_x_i,
  input  logic signed [DirW-1:0]   box_b_dir_y_i,
  input  logic [ExtW-1:0]          box_b_half_w_i,
  input  logic [ExtW-1:0]          box_b_half_h_i,
  output logic                     valid_o,
  output frame_t                   frame_o
);

  // stage 1
  logic                       v1_q;
  logic signed [DeltaW-1:0]   dx1_d, dy1_d, dx1_q, dy1_q;
  logic signed [DirW-1:0]     ax1_q, ay1_q;
  logic signed [DirProdW-1:0] pxx_d, pyy_d, pxy_d, pyx_d;
  logic signed [DirProdW-1:0] pxx_q, pyy_q, pxy_q, pyx_q;
  logic [ExtW-1:0]            aw1_q, ah1_q, bw1_q, bh1_q;

  assign dx1_d = DeltaW'(box_b_center_x_i) - DeltaW'(box_a_center_x_i);
  assign dy1_d = DeltaW'(box_b_center_y_i) - DeltaW'(box_a_center_y_i);
  assign pxx_d = DirProdW'(box_a_dir_x_i) * DirProdW'(box_b_dir_x_i);
  assign pyy_d = DirProdW'(box_a_dir_y_i) * DirProdW'(box_b_dir_y_i);
  assign pxy_d = DirProdW'(box_a_dir_x_i) * DirProdW'(box_b_dir_y_i);
  assign pyx_d = DirProdW'(box_a_dir_y_i) * DirProdW'(box_b_dir_x_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= dx1_d;
    dy1_q <= dy1_d;
    ax1_q <= box_a_dir_x_i;
    ay1_q <= box_a_dir_y_i;
    pxx_q <= pxx_d;
    pyy_q <= pyy_d;
    pxy_q <= pxy_d;
    pyx_q <= pyx_d;
    aw1_q <= box_a_half_w_i;
    ah1_q <= box_a_half_h_i;
    bw1_q <= box_b_half_w_i;
    bh1_q <= box_b_half_h_i;
  end

  // stage 2: r21 = -r12 and r22 = r11, so two rotation terms suffice
  logic                    v2_q;
  logic signed [RotW-1:0]  r11_d, r12_d, r11_q, r12_q;
  logic [AbsRotW-1:0]      eps;
  logic [AbsRotW-1:0]      a11_d, a12_d, a11_q, a12_q;
  logic signed [TW-1:0]    mxx_d, myy_d, mxy_d, myx_d;
  logic signed [TW-1:0]    mxx_q, myy_q, mxy_q, myx_q;
  logic [ExtW-1:0]         aw2_q, ah2_q, bw2_q, bh2_q;

  assign r11_d = RotW'(pxx_q) + RotW'(pyy_q);
  assign r12_d = RotW'(pxy_q) - RotW'(pyx_q);
  assign eps   = AbsRotW'(margin_i) << EpsShift;
  assign a11_d = (r11_d[RotW-1] ? AbsRotW'(-r11_d) : AbsRotW'(r11_d)) + eps;
  assign a12_d = (r12_d[RotW-1] ? AbsRotW'(-r12_d) : AbsRotW'(r12_d)) + eps;
  assign mxx_d = TW'(dx1_q) * TW'(ax1_q);
  assign myy_d = TW'(dy1_q) * TW'(ay1_q);
  assign mxy_d = TW'(dx1_q) * TW'(ay1_q);
  assign myx_d = TW'(dy1_q) * TW'(ax1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r11_q <= r11_d;
    r12_q <= r12_d;
    a11_q <= a11_d;
    a12_q <= a12_d;
    mxx_q <= mxx_d;
    myy_q <= myy_d;
    mxy_q <= mxy_d;
    myx_q <= myx_d;
    aw2_q <= aw1_q;
    ah2_q <= ah1_q;
    bw2_q <= bw1_q;
    bh2_q <= bh1_q;
  end

  // stage 3
  logic   v3_q;
  frame_t frame_d, frame_q;

  always_comb begin
    frame_d.tx     = mxx_q + myy_q;
    frame_d.ty     = mxy_q - myx_q;
    frame_d.r11    = r11_q;
    frame_d.r12    = r12_q;
    frame_d.aw     = aw2_q;
    frame_d.ah     = ah2_q;
    frame_d.bw     = bw2_q;
    frame_d.bh     = bh2_q;
    frame_d.bw_a11 = ExtProdW'(bw2_q) * ExtProdW'(a11_q);
    frame_d.bh_a12 = ExtProdW'(bh2_q) * ExtProdW'(a12_q);
    frame_d.bw_a12 = ExtProdW'(bw2_q) * ExtProdW'(a12_q);
    frame_d.bh_a11 = ExtProdW'(bh2_q) * ExtProdW'(a11_q);
    frame_d.aw_a11 = ExtProdW'(aw2_q) * ExtProdW'(a11_q);
    frame_d.ah_a12 = ExtProdW'(ah2_q) * ExtProdW'(a12_q);
    frame_d.aw_a12 = ExtProdW'(aw2_q) * ExtProdW'(a12_q);
    frame_d.ah_a11 = ExtProdW'(ah2_q) * ExtProdW'(a11_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign valid_o = v3_q;
  assign frame_o = frame_q;

endmodule

// ----- hw/rtl/obbsat_proj.sv -----
// Stages 4-6: axis projections, radius sums and the four separation compares.
module obbsat_proj import obbsat_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  frame_t frame_i,
  output logic   valid_o,
  output logic   overlap_o
);

  function automatic logic signed [WideW-1:0] join_part(
    input logic signed [PartW-1:0] hi,
    input logic signed [PartW-1:0] lo
  );
    logic signed [WideW-1:0] h;
    h = WideW'(hi);
    return (h <<< SplitLo) + WideW'(lo);
  endfunction

  // stage 4: tx, ty split into a signed high part and an unsigned low part
  logic signed [TW-1:0]       tx, ty;
  logic signed [RotW-1:0]     r11, r12;
  logic signed [SplitHiW-1:0] txh, txl, tyh, tyl;
  logic                       v4_q;
  logic signed [PartW-1:0]    txh11_q, txl11_q, tyh12_q, tyl12_q;
  logic signed [PartW-1:0]    txh12_q, txl12_q, tyh11_q, tyl11_q;
  logic [AbsTW-1:0]           atx_d, aty_d, atx_q, aty_q;
  logic [RhsW-1:0]            rhs1_d, rhs2_d, rhs1_q, rhs2_q;
  logic [SumW-1:0]            s3_d, s4_d, s3_q, s4_q;
  logic [ExtW-1:0]            bw4_q, bh4_q;

  assign tx  = $signed(frame_i.tx);
  assign ty  = $signed(frame_i.ty);
  assign r11 = $signed(frame_i.r11);
  assign r12 = $signed(frame_i.r12);
  assign txh = tx[TW-1:SplitLo];
  assign tyh = ty[TW-1:SplitLo];
  assign txl = $signed({{(SplitHiW-SplitLo){1'b0}}, tx[SplitLo-1:0]});
  assign tyl = $signed({{(SplitHiW-SplitLo){1'b0}}, ty[SplitLo-1:0]});

  assign atx_d  = tx[TW-1] ? AbsTW'(-tx) : AbsTW'(tx);
  assign aty_d  = ty[TW-1] ? AbsTW'(-ty) : AbsTW'(ty);
  assign rhs1_d = (RhsW'(frame_i.aw) << ExtAShift) + RhsW'(frame_i.bw_a11)
                + RhsW'(frame_i.bh_a12);
  assign rhs2_d = (RhsW'(frame_i.ah) << ExtAShift) + RhsW'(frame_i.bw_a12)
                + RhsW'(frame_i.bh_a11);
  assign s3_d   = SumW'(frame_i.aw_a11) + SumW'(frame_i.ah_a12);
  assign s4_d   = SumW'(frame_i.aw_a12) + SumW'(frame_i.ah_a11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    txh11_q <= PartW'(txh) * PartW'(r11);
    txl11_q <= PartW'(txl) * PartW'(r11);
    tyh12_q <= PartW'(tyh) * PartW'(r12);
    tyl12_q <= PartW'(tyl) * PartW'(r12);
    txh12_q <= PartW'(txh) * PartW'(r12);
    txl12_q <= PartW'(txl) * PartW'(r12);
    tyh11_q <= PartW'(tyh) * PartW'(r11);
    tyl11_q <= PartW'(tyl) * PartW'(r11);
    atx_q   <= atx_d;
    aty_q   <= aty_d;
    rhs1_q  <= rhs1_d;
    rhs2_q  <= rhs2_d;
    s3_q    <= s3_d;
    s4_q    <= s4_d;
    bw4_q   <= frame_i.bw;
    bh4_q   <= frame_i.bh;
  end

  // stage 5: B-axis projections, A-axis compares
  logic                    v5_q;
  logic signed [WideW-1:0] w3_d, w4_d, w3_q, w4_q;
  logic [RhsW-1:0]         lhs1, lhs2;
  logic                    sep12_d, sep12_q;
  logic [SumW-1:0]         s3_5_q, s4_5_q;
  logic [ExtW-1:0]         bw5_q, bh5_q;

  assign w3_d    = join_part(txh11_q, txl11_q) - join_part(tyh12_q, tyl12_q);
  assign w4_d    = join_part(txh12_q, txl12_q) + join_part(tyh11_q, tyl11_q);
  assign lhs1    = RhsW'(LhsW'(atx_q) << LhsShift);
  assign lhs2    = RhsW'(LhsW'(aty_q) << LhsShift);
  assign sep12_d = (lhs1 > rhs1_q) || (lhs2 > rhs2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w3_q    <= w3_d;
    w4_q    <= w4_d;
    sep12_q <= sep12_d;
    s3_5_q  <= s3_q;
    s4_5_q  <= s4_q;
    bw5_q   <= bw4_q;
    bh5_q   <= bh4_q;
  end

  // stage 6
  logic             v6_q, ovl_q;
  logic [WideW-1:0] aw3, aw4, wr3, wr4;
  logic             ovl_d;

  assign aw3   = w3_q[WideW-1] ? WideW'(-w3_q) : WideW'(w3_q);
  assign aw4   = w4_q[WideW-1] ? WideW'(-w4_q) : WideW'(w4_q);
  assign wr3   = (WideW'(s3_5_q) << SumShift) + (WideW'(bw5_q) << ExtBShift);
  assign wr4   = (WideW'(s4_5_q) << SumShift) + (WideW'(bh5_q) << ExtBShift);
  assign ovl_d = !(sep12_q || (aw3 > wr3) || (aw4 > wr4));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ovl_q <= ovl_d;
  end

  assign valid_o   = v6_q;
  assign overlap_o = ovl_q;

endmodule

// ----- hw/rtl/obb_overlap_test_2d_top.sv -----
// Top level of the 2D oriented box overlap test (separating axis test).
//
//   channel  | beat marked by           | payload
//   ---------+--------------------------+-----------------------------------
//   in       | start_i high, busy_o low | box_a_*_i, box_b_*_i
//   out      | done_o high, one cycle   | overlap_o
//   config   | axis_margin_we_i high    | axis_margin_i
//
// Six register stages: a beat accepted on start_i passes through all six before
// done_o rises with its result; one beat per cycle, since the pipeline never
// holds.
// busy_o is always low: the pipeline never holds and the receiver takes every
// result. Reset empties the pipeline and sets the margin to 2.
module obb_overlap_test_2d_top import obbsat_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     axis_margin_we_i,
  input  logic [MarginW-1:0]       axis_margin_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [CoordW-1:0] box_a_center_x_i,
  input  logic signed [CoordW-1:0] box_a_center_y_i,
  input  logic signed [DirW-1:0]   box_a_dir_x_i,
  input  logic signed [DirW-1:0]   box_a_dir_y_i,
  input  logic [ExtW-1:0]          box_a_half_w_i,
  input  logic [ExtW-1:0]          box_a_half_h_i,
  input  logic signed [CoordW-1:0] box_b_center_x_i,
  input  logic signed [CoordW-1:0] box_b_center_y_i,
  input  logic signed [DirW-1:0]   box_b_dir_x_i,
  input  logic signed [DirW-1:0]   box_b_dir_y_i,
  input  logic [ExtW-1:0]          box_b_half_w_i,
  input  logic [ExtW-1:0]          box_b_half_h_i,
  output logic                     done_o,
  output logic                     overlap_o
);

  logic [MarginW-1:0] margin_q;
  logic               in_valid;
  logic               frame_valid;
  frame_t             frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
    end else if (axis_margin_we_i) begin
      margin_q <= axis_margin_i;
    end
  end

  assign busy_o   = 1'b0;
  assign in_valid = start_i && !busy_o;

  obbsat_frame u_frame (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid),
    .margin_i         (margin_q),
    .box_a_center_x_i (box_a_center_x_i),
    .box_a_center_y_i (box_a_center_y_i),
    .box_a_dir_x_i    (box_a_dir_x_i),
    .box_a_dir_y_i    (box_a_dir_y_i),
    .box_a_half_w_i   (box_a_half_w_i),
    .box_a_half_h_i   (box_a_half_h_i),
    .box_b_center_x_i (box_b_center_x_i),
    .box_b_center_y_i (box_b_center_y_i),
    .box_b_dir_x_i    (box_b_dir_x_i),
    .box_b_dir_y_i    (box_b_dir_y_i),
    .box_b_half_w_i   (box_b_half_w_i),
    .box_b_half_h_i   (box_b_half_h_i),
    .valid_o          (frame_valid),
    .frame_o          (frame)
  );

  obbsat_proj u_proj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (frame_valid),
    .frame_i   (frame),
    .valid_o   (done_o),
    .overlap_o (overlap_o)
  );

endmodule

// ----- hw/rtl/obbsat_chk.sv -----
// Port-level checker for the overlap test top level, with its bind.
module obbsat_chk import obbsat_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic                     overlap_o,
  input logic signed [CoordW-1:0] box_a_center_x_i,
  input logic signed [CoordW-1:0] box_a_center_y_i,
  input logic signed [CoordW-1:0] box_b_center_x_i,
  input logic signed [CoordW-1:0] box_b_center_y_i
);

  localparam int unsigned Latency = 6;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == 1'b0)
    else $error("busy_o raised");

  a_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Latency !done_o)
    else $error("result without an accepted beat");

  a_same_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (box_a_center_x_i == box_b_center_x_i)
     && (box_a_center_y_i == box_b_center_y_i)) |-> ##Latency (done_o && overlap_o))
    else $error("coincident centers reported as separated");

endmodule

bind obb_overlap_test_2d_top obbsat_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .overlap_o        (overlap_o),
  .box_a_center_x_i (box_a_center_x_i),
  .box_a_center_y_i (box_a_center_y_i),
  .box_b_center_x_i (box_b_center_x_i),
  .box_b_center_y_i (box_b_center_y_i)
);
